FILE: rtl/sfs_pkg.sv
// Shared constants, types and helpers for the symbol frequency sorter.
package sfs_pkg;

    localparam int SYM_BITS       = 8;
    localparam int NUM_SYMS       = 1 << SYM_BITS;
    localparam int COUNT_BITS     = 16;
    localparam int OUT_COUNT_BITS = 16;
    localparam int TABLE_DEPTH    = 64;
    localparam int USED_BITS      = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_BITS       = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

    localparam logic [COUNT_BITS-1:0]     COUNT_MAX = '1;
    localparam logic [OUT_COUNT_BITS-1:0] OUT_MAX   = '1;

    typedef logic [SYM_BITS-1:0]       t_sym;
    typedef logic [COUNT_BITS-1:0]     t_count;
    typedef logic [OUT_COUNT_BITS-1:0] t_out_count;
    typedef logic [USED_BITS-1:0]      t_used;

    typedef struct packed {
        logic load;
        logic update;
        logic scan_start;
        logic scan_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic eom;
        logic scan_done;
        logic out_free;
        logic emit_last;
    } t_status;

    function automatic t_out_count sat_out(input t_count c);
        logic [CMP_BITS-1:0] w;
        w = CMP_BITS'(c);
        if (w > CMP_BITS'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return w[OUT_COUNT_BITS-1:0];
    endfunction

endpackage

FILE: rtl/sfs_in_if.sv
// Symbol input channel: valid/ready with symbol payload.
interface sfs_in_if import sfs_pkg::*; ();
    logic valid;
    logic ready;
    t_sym symbol_code;
    logic end_of_message;

    modport source (output valid, output symbol_code, output end_of_message, input ready);
    modport sink   (input valid, input symbol_code, input end_of_message, output ready);
endinterface

FILE: rtl/sfs_out_if.sv
// Sorted entry output channel: valid/ready with entry payload.
interface sfs_out_if import sfs_pkg::*; ();
    logic       valid;
    logic       ready;
    t_sym       entry_symbol;
    t_out_count entry_count;
    logic       table_overflowed;
    logic       last_entry;

    modport source (output valid, output entry_symbol, output entry_count,
                    output table_overflowed, output last_entry, input ready);
    modport sink   (input valid, input entry_symbol, input entry_count,
                    input table_overflowed, input last_entry, output ready);
endinterface

FILE: rtl/sfs_ctrl.sv
// Controller state machine: count update sequencing and sort/emit passes.
module sfs_ctrl import sfs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                if (i_status.eom) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/sfs_datapath.sv
// Datapath: symbol-indexed count memory, table bookkeeping, max scan, output register.
module sfs_datapath import sfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    input  t_sym      i_symbol_code,
    input  logic      i_end_of_message,
    sfs_out_if.source o_entry
);

    t_count mem_counts [NUM_SYMS];

    logic [NUM_SYMS-1:0] r_valid;
    t_sym   r_sym;
    logic   r_eom;
    logic   r_hit;
    t_count r_q;
    t_used  r_used;
    t_used  r_emitted;
    logic   r_ovf;

    t_sym   r_scan_addr;
    logic   r_issued_all;
    logic   r_rd_pend;
    logic   r_rd_v;
    t_sym   r_rd_sym;
    logic   r_best_found;
    t_sym   r_best_sym;
    t_count r_best_cnt;

    logic       r_out_valid;
    t_sym       r_out_sym;
    t_out_count r_out_cnt;
    logic       r_out_ovf;
    logic       r_out_last;

    t_sym   rd_addr;
    logic   wr_en;
    t_count wr_data;
    logic   new_entry;
    logic   set_ovf;
    logic   emit_last;
    logic   take_best;

    assign rd_addr   = i_cmd.load ? i_symbol_code : r_scan_addr;
    assign emit_last = (USED_BITS'(r_emitted + 1'b1) == r_used);
    assign take_best = r_rd_pend && r_rd_v && (!r_best_found || (r_q > r_best_cnt));

    always_comb begin
        wr_en     = 1'b0;
        wr_data   = r_q;
        new_entry = 1'b0;
        set_ovf   = 1'b0;
        if (i_cmd.update) begin
            priority if (r_hit) begin
                wr_en   = 1'b1;
                wr_data = (r_q == COUNT_MAX) ? r_q : COUNT_BITS'(r_q + 1'b1);
            end else if (r_used < USED_BITS'(TABLE_DEPTH)) begin
                wr_en     = 1'b1;
                wr_data   = COUNT_BITS'(1);
                new_entry = 1'b1;
            end else begin
                set_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_counts[r_sym] <= wr_data;
        end
        r_q <= mem_counts[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym <= i_symbol_code;
            r_eom <= i_end_of_message;
            r_hit <= r_valid[i_symbol_code];
        end
        if (i_cmd.scan_step && !r_issued_all) begin
            r_rd_v   <= r_valid[r_scan_addr];
            r_rd_sym <= r_scan_addr;
        end
        if (take_best) begin
            r_best_sym <= r_rd_sym;
            r_best_cnt <= r_q;
        end
        if (i_cmd.emit) begin
            r_out_sym  <= r_best_sym;
            r_out_cnt  <= sat_out(r_best_cnt);
            r_out_ovf  <= r_ovf;
            r_out_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_used       <= '0;
            r_emitted    <= '0;
            r_ovf        <= 1'b0;
            r_scan_addr  <= '0;
            r_issued_all <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (new_entry) begin
                r_valid[r_sym] <= 1'b1;
                r_used         <= USED_BITS'(r_used + 1'b1);
            end
            if (set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan_addr  <= t_sym'(NUM_SYMS - 1);
                r_issued_all <= 1'b0;
                r_rd_pend    <= 1'b0;
                r_best_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (!r_issued_all) begin
                    r_rd_pend <= 1'b1;
                    if (r_scan_addr == '0) begin
                        r_issued_all <= 1'b1;
                    end else begin
                        r_scan_addr <= t_sym'(r_scan_addr - 1'b1);
                    end
                end else begin
                    r_rd_pend <= 1'b0;
                end
            end
            if (take_best) begin
                r_best_found <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_valid[r_best_sym] <= 1'b0;
                r_out_valid         <= 1'b1;
                if (emit_last) begin
                    r_used    <= '0;
                    r_emitted <= '0;
                    r_ovf     <= 1'b0;
                end else begin
                    r_emitted <= USED_BITS'(r_emitted + 1'b1);
                end
            end else if (o_entry.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.eom       = r_eom;
    assign o_status.scan_done = r_issued_all && !r_rd_pend;
    assign o_status.out_free  = !r_out_valid || o_entry.ready;
    assign o_status.emit_last = emit_last;

    assign o_entry.valid            = r_out_valid;
    assign o_entry.entry_symbol     = r_out_sym;
    assign o_entry.entry_count      = r_out_cnt;
    assign o_entry.table_overflowed = r_out_ovf;
    assign o_entry.last_entry       = r_out_last;

endmodule

FILE: rtl/symbol_frequency_sorter.sv
// Top level: symbol frequency histogram with sorted emission at end of message.
// Each symbol is accepted with a count read in IDLE, then its count is updated in UPD.
// On the end-of-message symbol, each of the n table entries is found by a full
// 256-address scan of the count memory, which picks the largest remaining entry.
// Symbols wait for the prior update; results go through a one-entry output register.
// Reset: state, valid bits, counters and overflow flag clear; count memory keeps contents.
module symbol_frequency_sorter import sfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfs_in_if.sink    i_sym,
    sfs_out_if.source o_entry
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_sym.ready = in_ready;

    sfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sym.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sfs_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_symbol_code    (i_sym.symbol_code),
        .i_end_of_message (i_sym.end_of_message),
        .o_entry          (o_entry)
    );

    a_emit_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("emit while output register busy");

    a_one_symbol_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sym.valid && i_sym.ready) |=> !i_sym.ready)
        else $error("input accepted during count update");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && status.emit_last) |=> i_sym.ready)
        else $error("not ready after final entry");

endmodule

FILE: tb/tb_top.sv
// Testbench for symbol_frequency_sorter: directed and random messages against a sorted-histogram predictor.
`timescale 1ns / 100ps

module tb_top;
    import sfs_pkg::*;

    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        t_sym       sym;
        t_out_count count;
        logic       overflowed;
        logic       last;
    } t_entry;

    class freq_scoreboard;
        t_sym   table_syms[TABLE_DEPTH];
        t_count table_counts[TABLE_DEPTH];
        int     used_entries;
        bit     dropped_any;
        t_entry sorted_q[$];
        int     errors;

        function bit outranks(int a, int b);
            if (table_counts[a] != table_counts[b]) begin
                return table_counts[a] > table_counts[b];
            end
            return table_syms[a] > table_syms[b];
        endfunction

        function void note_symbol(t_sym s, logic eom);
            int          order[TABLE_DEPTH];
            int          j;
            int          hit;
            longint unsigned c;
            t_entry      e;
            hit = -1;
            for (int i = 0; i < used_entries; i++) begin
                if (table_syms[i] == s) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                if (table_counts[hit] != COUNT_MAX) begin
                    table_counts[hit]++;
                end
            end else if (used_entries < TABLE_DEPTH) begin
                table_syms[used_entries] = s;
                table_counts[used_entries] = 1;
                used_entries++;
            end else begin
                dropped_any = 1;
            end
            if (!eom) begin
                return;
            end
            for (int i = 0; i < used_entries; i++) begin
                j = i;
                while (j > 0 && outranks(i, order[j-1])) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            for (int i = 0; i < used_entries; i++) begin
                c = table_counts[order[i]];
                e.sym        = table_syms[order[i]];
                e.count      = (c > OUT_MAX) ? OUT_MAX : t_out_count'(c);
                e.overflowed = dropped_any;
                e.last       = (i == used_entries - 1);
                sorted_q.push_back(e);
            end
            used_entries = 0;
            dropped_any  = 0;
        endfunction

        function void check_entry(t_entry got);
            t_entry exp;
            if (sorted_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected entry: sym %02h count %0d ovf %0b last %0b",
                             got.sym, got.count, got.overflowed, got.last);
                end
                return;
            end
            exp = sorted_q.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10) begin
                    $display("entry mismatch: exp sym %02h count %0d ovf %0b last %0b",
                             exp.sym, exp.count, exp.overflowed, exp.last);
                    $display("                got sym %02h count %0d ovf %0b last %0b",
                             got.sym, got.count, got.overflowed, got.last);
                end
            end
        endfunction

        function int outstanding();
            return sorted_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    int   quiet_cycles;
    t_sym perm[NUM_SYMS];
    t_sym msg_q[$];

    freq_scoreboard sb = new();

    sfs_in_if  sym_if ();
    sfs_out_if entry_if ();

    symbol_frequency_sorter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (sym_if),
        .o_entry (entry_if)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (sym_if.valid && sym_if.ready) || (entry_if.valid && entry_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result side: optional hold while the block presents a result
    initial begin
        int     hold;
        t_entry got;
        entry_if.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            hold = idle_on ? $urandom_range(0, 5) : 0;
            if (hold == 0) begin
                entry_if.ready = 1'b1;
                do @(posedge i_clk); while (!entry_if.valid);
            end else begin
                entry_if.ready = 1'b0;
                do @(posedge i_clk); while (!entry_if.valid);
                repeat (hold) @(negedge i_clk);
                entry_if.ready = 1'b1;
                do @(posedge i_clk); while (!entry_if.valid);
            end
            got.sym        = entry_if.entry_symbol;
            got.count      = entry_if.entry_count;
            got.overflowed = entry_if.table_overflowed;
            got.last       = entry_if.last_entry;
            sb.check_entry(got);
            @(negedge i_clk);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_symbol(input t_sym s, input logic eom);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            sym_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sym_if.valid          = 1'b1;
        sym_if.symbol_code    = s;
        sym_if.end_of_message = eom;
        do @(posedge i_clk); while (!sym_if.ready);
        sb.note_symbol(s, eom);
        @(negedge i_clk);
    endtask

    task automatic send_message();
        for (int k = 0; k < msg_q.size(); k++) begin
            send_symbol(msg_q[k], k == msg_q.size() - 1);
        end
    endtask

    task automatic wait_drained();
        sym_if.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic shuffle_symbols();
        int   r;
        t_sym t;
        for (int i = 0; i < NUM_SYMS; i++) begin
            perm[i] = t_sym'(i);
        end
        for (int i = NUM_SYMS - 1; i > 0; i--) begin
            r = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[r];
            perm[r] = t;
        end
    endtask

    // fills the table from 64 fresh symbols, then keeps counting and dropping
    task automatic build_overflow(input int extra, input bit end_on_new);
        int placed;
        shuffle_symbols();
        msg_q.delete();
        placed = 0;
        while (placed < TABLE_DEPTH) begin
            if (placed > 0 && $urandom_range(0, 2) == 0) begin
                msg_q.push_back(perm[$urandom_range(0, placed - 1)]);
            end else begin
                msg_q.push_back(perm[placed]);
                placed++;
            end
        end
        for (int k = 0; k < extra; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                msg_q.push_back(perm[TABLE_DEPTH + $urandom_range(0, NUM_SYMS - TABLE_DEPTH - 1)]);
            end else begin
                msg_q.push_back(perm[$urandom_range(0, TABLE_DEPTH - 1)]);
            end
        end
        if (end_on_new) begin
            msg_q.push_back(perm[TABLE_DEPTH + $urandom_range(0, NUM_SYMS - TABLE_DEPTH - 1)]);
        end
    endtask

    task automatic build_random(input int alph, input int len);
        shuffle_symbols();
        msg_q.delete();
        for (int k = 0; k < len; k++) begin
            msg_q.push_back(perm[$urandom_range(0, alph - 1)]);
        end
    endtask

    initial begin
        int sent;
        int kind;
        int alph;
        bit first;
        i_rst_n               = 1'b0;
        idle_on               = 1'b1;
        sym_if.valid          = 1'b0;
        sym_if.symbol_code    = '0;
        sym_if.end_of_message = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single entry, extremes and ties, repeats with eom on a known symbol
        msg_q = '{8'h00};
        send_message();
        msg_q = '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F};
        send_message();
        msg_q = '{8'hAA, 8'h55, 8'hAA, 8'h0F, 8'h55, 8'hAA, 8'h0F, 8'h55, 8'h55};
        send_message();
        msg_q = '{8'h3C, 8'hC3, 8'hC3, 8'h3C};
        send_message();
        wait_drained();

        sent  = 0;
        first = 1'b1;
        while (sent < 220) begin
            idle_on = ($urandom_range(0, 3) != 0);
            kind = first ? 0 : $urandom_range(0, 9);
            if (kind == 0) begin
                build_overflow($urandom_range(1, 20), first || $urandom_range(0, 1));
            end else if (kind <= 6) begin
                build_random($urandom_range(1, 8), $urandom_range(1, 12));
            end else if (kind <= 8) begin
                alph = $urandom_range(9, 40);
                build_random(alph, $urandom_range(alph, alph + 30));
            end else begin
                build_overflow(0, 1'b0);
            end
            first = 1'b0;
            send_message();
            sent += msg_q.size();
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (600) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
